// ===== rtl/core/kfa_pkg.sv =====
`default_nettype none

package kfa_pkg;

  // Field widths of the request and response items
  localparam int unsigned CmdW    = 2;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned NumW    = 7;
  localparam int unsigned StatusW = 3;

  // Table size and stored key width; numbers 1..Slots must fit in NumW bits
  localparam int unsigned Slots   = 64;
  localparam int unsigned KeyBits = 32;
  localparam int unsigned IdxW    = $clog2(Slots);

  typedef enum logic [CmdW-1:0] {
    CmdLease  = 2'd0,
    CmdRelNum = 2'd1,
    CmdRelKey = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StExisting = 3'd0,
    StNew      = 3'd1,
    StFull     = 3'd2,
    StInvalid  = 3'd3,
    StReleased = 3'd4,
    StNotFound = 3'd5
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [KeyBits-1:0] key;
    logic [NumW-1:0]    num;
  } req_t;

  typedef struct packed {
    logic [NumW-1:0] granted;
    status_e         status;
  } rsp_t;

  // At most one slot changes per item
  typedef struct packed {
    logic            set;
    logic            clr;
    logic [IdxW-1:0] idx;
  } slot_op_t;

  typedef struct packed {
    logic            found;
    logic [IdxW-1:0] idx;
  } prio_t;

  // Lowest set bit of a slot vector
  function automatic prio_t first_set(input logic [Slots-1:0] vec);
    prio_t res;
    res.found = |vec;
    res.idx   = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.idx = IdxW'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kfa_req_if.sv =====
`default_nettype none

interface kfa_req_if;
  import kfa_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [KeyW-1:0] client_key;
  logic [NumW-1:0] id_number;

  modport source (output valid, output cmd, output client_key, output id_number,
                  input ready);
  modport sink   (input valid, input cmd, input client_key, input id_number,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kfa_rsp_if.sv =====
`default_nettype none

interface kfa_rsp_if;
  import kfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [NumW-1:0]    granted_number;
  logic [StatusW-1:0] status;

  modport source (output valid, output granted_number, output status, input ready);
  modport sink   (input valid, input granted_number, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kfa_key_cam.sv =====
`default_nettype none

module kfa_key_cam (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [kfa_pkg::IdxW-1:0]    widx_i,
  input  logic [kfa_pkg::KeyBits-1:0] wkey_i,
  input  logic [kfa_pkg::KeyBits-1:0] key_i,
  output logic [kfa_pkg::Slots-1:0]   eq_o
);
  import kfa_pkg::*;

  logic [KeyBits-1:0] keys_q [Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      keys_q[widx_i] <= wkey_i;
    end
  end

  // Every entry compares against the search key; the used map masks stale entries
  always_comb begin
    for (int i = 0; i < Slots; i++) begin
      eq_o[i] = (keys_q[i] == key_i);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/kfa_slot_map.sv =====
`default_nettype none

module kfa_slot_map (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kfa_pkg::slot_op_t         op_i,
  output logic [kfa_pkg::Slots-1:0] used_o,
  output kfa_pkg::prio_t            free_o
);
  import kfa_pkg::*;

  logic [Slots-1:0] used_q;
  logic [Slots-1:0] used_d;

  always_comb begin
    used_d = used_q;
    if (op_i.set) begin
      used_d[op_i.idx] = 1'b1;
    end
    if (op_i.clr) begin
      used_d[op_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign used_o = used_q;
  assign free_o = first_set(~used_q);

endmodule

`default_nettype wire

// ===== rtl/core/kfa_decide.sv =====
`default_nettype none

module kfa_decide (
  input  kfa_pkg::req_t             req_i,
  input  logic [kfa_pkg::Slots-1:0] used_i,
  input  logic [kfa_pkg::Slots-1:0] key_eq_i,
  input  kfa_pkg::prio_t            free_i,
  output kfa_pkg::rsp_t             rsp_o,
  output kfa_pkg::slot_op_t         op_o
);
  import kfa_pkg::*;

  prio_t           hit;
  logic            key_nz;
  logic            num_nz;
  logic            in_range;
  logic [NumW-1:0] num_idx;
  logic            num_used;

  assign hit      = first_set(key_eq_i & used_i);
  assign key_nz   = |req_i.key;
  assign num_nz   = |req_i.num;
  assign in_range = (req_i.num <= NumW'(Slots));
  assign num_idx  = req_i.num - NumW'(1);
  assign num_used = in_range && used_i[num_idx[IdxW-1:0]];

  always_comb begin
    rsp_o.granted = '0;
    rsp_o.status  = StInvalid;
    op_o.set      = 1'b0;
    op_o.clr      = 1'b0;
    op_o.idx      = '0;
    case (req_i.cmd)
      CmdLease: begin
        if (key_nz) begin
          if (hit.found) begin
            rsp_o.granted = NumW'(hit.idx) + NumW'(1);
            rsp_o.status  = StExisting;
          end else if (free_i.found) begin
            rsp_o.granted = NumW'(free_i.idx) + NumW'(1);
            rsp_o.status  = StNew;
            op_o.set      = 1'b1;
            op_o.idx      = free_i.idx;
          end else begin
            rsp_o.status  = StFull;
          end
        end
      end
      CmdRelNum: begin
        if (num_nz) begin
          if (num_used) begin
            rsp_o.granted = req_i.num;
            rsp_o.status  = StReleased;
            op_o.clr      = 1'b1;
            op_o.idx      = num_idx[IdxW-1:0];
          end else begin
            rsp_o.status  = StNotFound;
          end
        end
      end
      CmdRelKey: begin
        if (key_nz) begin
          if (hit.found) begin
            rsp_o.granted = NumW'(hit.idx) + NumW'(1);
            rsp_o.status  = StReleased;
            op_o.clr      = 1'b1;
            op_o.idx      = hit.idx;
          end else begin
            rsp_o.status  = StNotFound;
          end
        end
      end
      default: begin
        rsp_o.status = StInvalid;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/keyed_lowest_free_id_allocator.sv =====
// Channel | Dir | Fields                         | Transfer
// req_i   | in  | cmd, client_key, id_number     | valid && ready
// rsp_o   | out | granted_number, status         | valid && ready
//
// One request per cycle sustained while rsp_o is ready; each result is registered in out_q.
// The compute stage does the key compare over all 64 slots and the two priority
// encoders, with the slot map and key store updated as the item leaves it.
// Reset clears the used map at once; the key store needs no clearing pass.
// A stalled result holds its register and the request register behind it; a new
// request is still taken while the request register is empty.
`default_nettype none

module keyed_lowest_free_id_allocator (
  input  logic      clk_i,
  input  logic      rst_ni,
  kfa_req_if.sink   req_i,
  kfa_rsp_if.source rsp_o
);
  import kfa_pkg::*;

  logic       in_valid_q;
  logic       in_valid_d;
  req_t       in_q;
  logic       out_valid_q;
  logic       out_valid_d;
  rsp_t       out_q;
  logic       advance;
  logic       out_free;

  logic [Slots-1:0] used;
  logic [Slots-1:0] key_eq;
  prio_t            free;
  rsp_t             res;
  slot_op_t         op;
  slot_op_t         op_gated;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || advance;

  assign in_valid_d  = req_i.ready ? req_i.valid : in_valid_q;
  assign out_valid_d = out_free ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.cmd <= req_i.cmd;
      in_q.key <= req_i.client_key[KeyBits-1:0];
      in_q.num <= req_i.id_number;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  // Commit the table change only when the item leaves the compute stage
  always_comb begin
    op_gated     = op;
    op_gated.set = op.set && advance;
    op_gated.clr = op.clr && advance;
  end

  kfa_key_cam u_cam (
    .clk_i  (clk_i),
    .we_i   (op_gated.set),
    .widx_i (op.idx),
    .wkey_i (in_q.key),
    .key_i  (in_q.key),
    .eq_o   (key_eq)
  );

  kfa_slot_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_gated),
    .used_o (used),
    .free_o (free)
  );

  kfa_decide u_decide (
    .req_i    (in_q),
    .used_i   (used),
    .key_eq_i (key_eq),
    .free_i   (free),
    .rsp_o    (res),
    .op_o     (op)
  );

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.granted_number = out_q.granted;
  assign rsp_o.status         = out_q.status;

  a_set_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op.set) |-> !used[op.idx])
    else $error("lease binds a slot that is already used");

  a_clr_used_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op.clr) |-> used[op.idx])
    else $error("release frees a slot that is not used");

  a_no_dup_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op.set) |-> !(|(key_eq & used)))
    else $error("lease binds a key that already holds a slot");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.status == StFull) |-> (&used))
    else $error("full reported with a free slot");

  a_set_commits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op.set) |=> used[$past(op.idx)])
    else $error("leased slot not marked used");

endmodule

`default_nettype wire
